[rtl/core/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, types and helpers for the polygon plane split/clip block.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int COORD_BITS = 16;
	localparam int NORM_W     = 16;
	localparam int OFF_W      = 34;
	localparam int CFG_IDX_W  = 3;
	// Signed distance width: three products plus offset, with headroom.
	localparam int DIST_W  = ((COORD_BITS + 18 > OFF_W) ? COORD_BITS + 18 : OFF_W) + 2;
	localparam int A_W     = COORD_BITS + 2;
	localparam int B_W     = DIST_W + 1;
	localparam int PROD_W  = A_W + B_W;
	localparam int QB      = COORD_BITS + 1;
	localparam int DEN_W   = DIST_W + 1;
	localparam int CNT_W   = $clog2(QB + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_X   = 3'd0,
		REG_NORMAL_Y   = 3'd1,
		REG_NORMAL_Z   = 3'd2,
		REG_OFFSET     = 3'd3,
		REG_EMIT_POS   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [OFF_W-1:0]  off;
		logic                     emit_pos;
	} cfg_t;

	typedef enum logic [1:0] {
		ARITH_IDLE,
		ARITH_MUL,
		ARITH_DIV_LOAD,
		ARITH_DIV_STEP
	} arith_op_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic [QB-1:0]            quo;
	} arith_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DMUL,
		ST_DFIN,
		ST_PLAN,
		ST_EDGE,
		ST_XMUL,
		ST_XLOAD,
		ST_XDIV,
		ST_XSTORE,
		ST_EMIT,
		ST_DONE
	} state_t;

	// Result slots of one edge, in emission order.
	localparam logic [1:0] SLOT_NEG_KEEP  = 2'd0;
	localparam logic [1:0] SLOT_NEG_CROSS = 2'd1;
	localparam logic [1:0] SLOT_POS_KEEP  = 2'd2;
	localparam logic [1:0] SLOT_POS_CROSS = 2'd3;

	// Which slots an edge (p,q) emits.
	function automatic logic [3:0] edge_plan(input logic signed [DIST_W-1:0] dp,
			input logic signed [DIST_W-1:0] dq, input logic emit_pos);
		logic [3:0] m;
		logic pn, pz, qn, qz;
		pn = dp[DIST_W-1];
		pz = (dp == '0);
		qn = dq[DIST_W-1];
		qz = (dq == '0);
		m[SLOT_NEG_KEEP]  = pn;
		m[SLOT_NEG_CROSS] = (pn && !qn) || (!pn && qn);
		m[SLOT_POS_KEEP]  = emit_pos && !pn && !pz;
		m[SLOT_POS_CROSS] = emit_pos && (((!pn && !pz) && (qn || qz))
			|| ((pn || pz) && (!qn && !qz)));
		return m;
	endfunction

endpackage

[rtl/core/polygon_plane_split_clip.sv]
// ----------------------------------------------------------------------------
// polygon_plane_split_clip
// Splits or clips a polygon, given vertex by vertex, against one plane.
// ----------------------------------------------------------------------------
// One vertex word is taken at a time and vtx_stall stays high until all of
// its results have been handed to the result register. The distance is
// formed from three products on the shared multiplier. Each edge with any
// result then passes an edge state, one multiply and a restoring division of
// COORD_BITS+1 steps for each of three axes when it needs a plane crossing,
// and a walk over its four result slots, one slot per cycle when the output
// side does not stall.
module polygon_plane_split_clip (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 vtx_valid,
	output logic                                 vtx_stall,
	input  logic signed [pps_pkg::COORD_BITS-1:0] vx,
	input  logic signed [pps_pkg::COORD_BITS-1:0] vy,
	input  logic signed [pps_pkg::COORD_BITS-1:0] vz,
	input  logic                                 final_vertex,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [pps_pkg::COORD_BITS-1:0] ox,
	output logic signed [pps_pkg::COORD_BITS-1:0] oy,
	output logic signed [pps_pkg::COORD_BITS-1:0] oz,
	output logic                                 side,
	output logic                                 is_crossing,
	output logic                                 run_end,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pps_pkg::OFF_W-1:0]            cfg_data
);

	localparam int C = pps_pkg::COORD_BITS;
	localparam int D = pps_pkg::DIST_W;

	pps_pkg::cfg_t       cfg;
	pps_pkg::state_t     state_q, state_d;
	pps_pkg::arith_op_t  op;
	pps_pkg::arith_res_t ares;
	logic signed [pps_pkg::A_W-1:0] op_a;
	logic signed [pps_pkg::B_W-1:0] op_b;

	logic signed [C-1:0] v_q [3];
	logic signed [C-1:0] prev_q [3];
	logic signed [C-1:0] first_q [3];
	logic signed [C-1:0] cross_q [3];
	logic signed [D-1:0] dv_q, dprev_q, dfirst_q, acc_q;
	logic                fin_q, open_q, neg_q, e_q;
	logic [1:0]          s_q, ax_q;
	logic [7:0]          mask_q;
	logic [pps_pkg::CNT_W-1:0] cnt_q;
	logic [pps_pkg::DEN_W-1:0] den_q;
	logic                den_neg_q;

	logic signed [C-1:0] res_x_q, res_y_q, res_z_q;
	logic                res_valid_q, res_side_q, res_cross_q, res_end_q;

	logic signed [C-1:0] p_c [3];
	logic signed [C-1:0] q_c [3];
	logic signed [D-1:0] dp_c, dq_c;
	logic signed [D:0]   den_c;
	logic [3:0]          edge_m;
	logic [2:0]          idx;
	logic                slot_on, out_free, emit_go, advance, last_res;
	logic signed [C:0]   delta_c, sum_c;

	pps_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pps_arith u_arith (
		.clk (clk),
		.op  (op),
		.a   (op_a),
		.b   (op_b),
		.den (den_q),
		.res (ares)
	);

	assign cfg_ready = 1'b1;
	assign vtx_stall = (state_q != pps_pkg::ST_IDLE);

	// Current edge: (prev, v) first, then (v, first) on a closing vertex.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_c[k] = e_q ? v_q[k] : prev_q[k];
			q_c[k] = e_q ? first_q[k] : v_q[k];
		end
		dp_c   = e_q ? dv_q : dprev_q;
		dq_c   = e_q ? dfirst_q : dv_q;
		den_c  = {dp_c[D-1], dp_c} - {dq_c[D-1], dq_c};
		edge_m = e_q ? mask_q[7:4] : mask_q[3:0];
	end

	assign delta_c  = {q_c[ax_q][C-1], q_c[ax_q]} - {p_c[ax_q][C-1], p_c[ax_q]};
	assign sum_c    = neg_q ? ({p_c[ax_q][C-1], p_c[ax_q]} - ares.quo[C:0])
		: ({p_c[ax_q][C-1], p_c[ax_q]} + ares.quo[C:0]);

	assign idx      = {e_q, s_q};
	assign slot_on  = mask_q[idx];
	assign out_free = !res_valid_q || !res_stall;
	assign emit_go  = (state_q == pps_pkg::ST_EMIT) && slot_on && out_free;
	assign advance  = (state_q == pps_pkg::ST_EMIT) && (!slot_on || out_free);
	assign last_res = (((mask_q >> idx) >> 1) == 8'd0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pps_pkg::ST_IDLE:  if (vtx_valid) state_d = pps_pkg::ST_DMUL;
			pps_pkg::ST_DMUL:  if (cnt_q == pps_pkg::CNT_W'(3)) state_d = pps_pkg::ST_DFIN;
			pps_pkg::ST_DFIN:  state_d = pps_pkg::ST_PLAN;
			pps_pkg::ST_PLAN: begin
				if (!open_q && !fin_q) state_d = pps_pkg::ST_IDLE;
				else state_d = pps_pkg::ST_EDGE;
			end
			pps_pkg::ST_EDGE: begin
				if (edge_m == 4'd0) state_d = e_q ? pps_pkg::ST_DONE : pps_pkg::ST_EDGE;
				else if (edge_m[pps_pkg::SLOT_NEG_CROSS] || edge_m[pps_pkg::SLOT_POS_CROSS])
					state_d = pps_pkg::ST_XMUL;
				else state_d = pps_pkg::ST_EMIT;
			end
			pps_pkg::ST_XMUL:  state_d = pps_pkg::ST_XLOAD;
			pps_pkg::ST_XLOAD: state_d = pps_pkg::ST_XDIV;
			pps_pkg::ST_XDIV:  if (cnt_q == pps_pkg::CNT_W'(pps_pkg::QB - 1))
				state_d = pps_pkg::ST_XSTORE;
			pps_pkg::ST_XSTORE: state_d = (ax_q == 2'd2) ? pps_pkg::ST_EMIT : pps_pkg::ST_XMUL;
			pps_pkg::ST_EMIT: begin
				if (advance && s_q == 2'd3) state_d = e_q ? pps_pkg::ST_DONE : pps_pkg::ST_EDGE;
			end
			pps_pkg::ST_DONE:  state_d = pps_pkg::ST_IDLE;
			default:           state_d = pps_pkg::ST_IDLE;
		endcase
	end

	// Shared unit control and operands.
	always_comb begin
		op   = pps_pkg::ARITH_IDLE;
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			pps_pkg::ST_DMUL: begin
				if (cnt_q != pps_pkg::CNT_W'(3)) begin
					op   = pps_pkg::ARITH_MUL;
					op_a = pps_pkg::A_W'(v_q[cnt_q[1:0]]);
					unique case (cnt_q[1:0])
						2'd0:    op_b = pps_pkg::B_W'(cfg.nx);
						2'd1:    op_b = pps_pkg::B_W'(cfg.ny);
						default: op_b = pps_pkg::B_W'(cfg.nz);
					endcase
				end
			end
			pps_pkg::ST_XMUL: begin
				op   = pps_pkg::ARITH_MUL;
				op_a = pps_pkg::A_W'(delta_c);
				op_b = pps_pkg::B_W'(dp_c);
			end
			pps_pkg::ST_XLOAD: op = pps_pkg::ARITH_DIV_LOAD;
			pps_pkg::ST_XDIV:  op = pps_pkg::ARITH_DIV_STEP;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pps_pkg::ST_IDLE;
			open_q      <= 1'b0;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			e_q         <= 1'b0;
			s_q         <= 2'd0;
			ax_q        <= 2'd0;
			mask_q      <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit_go || (res_valid_q && res_stall);
			unique case (state_q)
				pps_pkg::ST_IDLE: begin
					cnt_q <= '0;
					e_q   <= 1'b0;
				end
				pps_pkg::ST_DMUL: cnt_q <= cnt_q + 1'b1;
				pps_pkg::ST_PLAN: begin
					if (!open_q) begin
						if (fin_q) begin
							// A lone vertex is kept on its own side only.
							mask_q <= {4'd0, 1'b0, cfg.emit_pos && !dv_q[D-1], 1'b0, dv_q[D-1]};
						end else begin
							open_q <= 1'b1;
						end
					end else begin
						mask_q[3:0] <= pps_pkg::edge_plan(dprev_q, dv_q, cfg.emit_pos);
						mask_q[7:4] <= fin_q ? pps_pkg::edge_plan(dv_q, dfirst_q, cfg.emit_pos)
							: 4'd0;
					end
				end
				pps_pkg::ST_EDGE: begin
					s_q   <= 2'd0;
					ax_q  <= 2'd0;
					if (edge_m == 4'd0) e_q <= 1'b1;
				end
				pps_pkg::ST_XLOAD: cnt_q <= '0;
				pps_pkg::ST_XDIV:  cnt_q <= cnt_q + 1'b1;
				pps_pkg::ST_XSTORE: ax_q <= ax_q + 2'd1;
				pps_pkg::ST_EMIT: begin
					if (advance) begin
						s_q <= s_q + 2'd1;
						if (s_q == 2'd3) e_q <= 1'b1;
					end
				end
				pps_pkg::ST_DONE: begin
					if (open_q && fin_q) open_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == pps_pkg::ST_IDLE && vtx_valid) begin
			v_q[0] <= vx;
			v_q[1] <= vy;
			v_q[2] <= vz;
			fin_q  <= final_vertex;
			acc_q  <= '0;
		end
		if (state_q == pps_pkg::ST_DMUL && cnt_q != '0)
			acc_q <= acc_q + ares.prod[D-1:0];
		if (state_q == pps_pkg::ST_DFIN)
			dv_q <= acc_q - D'(cfg.off);
		if (state_q == pps_pkg::ST_PLAN) begin
			if (!open_q) begin
				// A lone vertex is emitted from the previous-vertex slot.
				prev_q  <= v_q;
				dprev_q <= dv_q;
				if (!fin_q) begin
					first_q  <= v_q;
					dfirst_q <= dv_q;
				end
			end
		end
		if (state_q == pps_pkg::ST_EDGE) begin
			den_neg_q <= den_c[D];
			den_q     <= den_c[D] ? pps_pkg::DEN_W'(-den_c) : pps_pkg::DEN_W'(den_c);
		end
		if (state_q == pps_pkg::ST_XLOAD)
			neg_q <= ares.prod[pps_pkg::PROD_W-1] ^ den_neg_q;
		if (state_q == pps_pkg::ST_XSTORE)
			cross_q[ax_q] <= sum_c[C-1:0];
		if (state_q == pps_pkg::ST_DONE && open_q && !fin_q) begin
			prev_q  <= v_q;
			dprev_q <= dv_q;
		end
		if (emit_go) begin
			res_x_q     <= s_q[0] ? cross_q[0] : p_c[0];
			res_y_q     <= s_q[0] ? cross_q[1] : p_c[1];
			res_z_q     <= s_q[0] ? cross_q[2] : p_c[2];
			res_side_q  <= s_q[1];
			res_cross_q <= s_q[0];
			res_end_q   <= last_res;
		end
	end

	assign res_valid   = res_valid_q;
	assign ox          = res_x_q;
	assign oy          = res_y_q;
	assign oz          = res_z_q;
	assign side        = res_side_q;
	assign is_crossing = res_cross_q;
	assign run_end     = res_end_q;

endmodule

[rtl/core/pps_regs.sv]
// ----------------------------------------------------------------------------
// pps_regs
// Plane configuration registers written through the configuration port.
// ----------------------------------------------------------------------------
module pps_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pps_pkg::OFF_W-1:0]      cfg_data,
	output pps_pkg::cfg_t                  cfg
);

	pps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nx       <= '0;
			cfg_q.ny       <= '0;
			cfg_q.nz       <= pps_pkg::NORM_W'(1);
			cfg_q.off      <= '0;
			cfg_q.emit_pos <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pps_pkg::REG_NORMAL_X: cfg_q.nx <= cfg_data[pps_pkg::NORM_W-1:0];
				pps_pkg::REG_NORMAL_Y: cfg_q.ny <= cfg_data[pps_pkg::NORM_W-1:0];
				pps_pkg::REG_NORMAL_Z: cfg_q.nz <= cfg_data[pps_pkg::NORM_W-1:0];
				pps_pkg::REG_OFFSET:   cfg_q.off <= cfg_data;
				pps_pkg::REG_EMIT_POS: cfg_q.emit_pos <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/pps_arith.sv]
// ----------------------------------------------------------------------------
// pps_arith
// Shared arithmetic unit: one signed multiplier and a restoring divide step.
// ----------------------------------------------------------------------------
module pps_arith (
	input  logic                               clk,
	input  pps_pkg::arith_op_t                 op,
	input  logic signed [pps_pkg::A_W-1:0]     a,
	input  logic signed [pps_pkg::B_W-1:0]     b,
	input  logic [pps_pkg::DEN_W-1:0]          den,
	output pps_pkg::arith_res_t                res
);

	logic signed [pps_pkg::PROD_W-1:0] prod_q;
	logic [pps_pkg::DEN_W-1:0]         rem_q;
	logic [pps_pkg::QB-1:0]            num_q;
	logic [pps_pkg::QB-1:0]            quo_q;
	logic [pps_pkg::PROD_W-1:0]        mag;
	logic [pps_pkg::DEN_W:0]           trial;
	logic [pps_pkg::DEN_W:0]           diff;
	logic                              fits;

	assign mag   = prod_q[pps_pkg::PROD_W-1] ? (~prod_q + 1'b1) : prod_q;
	assign trial = {rem_q, num_q[pps_pkg::QB-1]};
	assign diff  = trial - {1'b0, den};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk) begin
		unique case (op)
			pps_pkg::ARITH_MUL: begin
				prod_q <= a * b;
			end
			pps_pkg::ARITH_DIV_LOAD: begin
				// The top part of the numerator is already below the divisor.
				rem_q <= mag[pps_pkg::QB +: pps_pkg::DEN_W];
				num_q <= mag[pps_pkg::QB-1:0];
				quo_q <= '0;
			end
			pps_pkg::ARITH_DIV_STEP: begin
				rem_q <= fits ? diff[pps_pkg::DEN_W-1:0] : trial[pps_pkg::DEN_W-1:0];
				num_q <= {num_q[pps_pkg::QB-2:0], 1'b0};
				quo_q <= {quo_q[pps_pkg::QB-2:0], fits};
			end
			default: ;
		endcase
	end

	assign res.prod = prod_q;
	assign res.quo  = quo_q;

endmodule

[rtl/core/pps_checker.sv]
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the polygon plane split/clip block.
// ----------------------------------------------------------------------------
module pps_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 vtx_valid,
	input logic                                 vtx_stall,
	input logic                                 res_valid,
	input logic                                 res_stall,
	input logic signed [pps_pkg::COORD_BITS-1:0] ox,
	input logic                                 side,
	input logic                                 is_crossing,
	input logic                                 run_end
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(ox) && $stable(side)
			&& $stable(is_crossing) && $stable(run_end))
		else $error("stalled result word changed");

	// An accepted vertex keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall |=> vtx_stall)
		else $error("vertex accepted but block not busy");

	// A new result word only comes out of a busy block.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(vtx_stall))
		else $error("result word appeared while idle");

endmodule

bind polygon_plane_split_clip pps_checker u_pps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.vtx_valid   (vtx_valid),
	.vtx_stall   (vtx_stall),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.ox          (ox),
	.side        (side),
	.is_crossing (is_crossing),
	.run_end     (run_end)
);
